>>> hdl/rsp_pkg.sv
// ----------------------------------------------------------------------------
// rsp_pkg - shared types and constants of the sprite palette remap block
// Holds the parse phase type, the request kinds, the register indexes and the
// record that travels from the parser to the remap stage.
// ----------------------------------------------------------------------------
package rsp_pkg;

  // Request kinds on the input channel.
  localparam logic KIND_SPRITE = 1'b0;
  localparam logic KIND_TABLE  = 1'b1;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 1'b1;
  localparam int unsigned CFG_DATA_W = 9;

  // Header is four bytes long; its last byte has this position.
  localparam logic [1:0] HDR_LAST = 2'd3;

  // Decoupling queue between parser and remap stage.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_OFFSETS = 3'd1,
    PH_SKIP    = 3'd2,
    PH_RUN     = 3'd3,
    PH_PIXELS  = 3'd4
  } rsp_phase_e;

  // One classified request as handed to the remap stage.
  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic [7:0] index;
    logic       is_pixel;
    logic       last;
    logic       use_remap;
  } rsp_item_t;

endpackage

>>> hdl/rsp_front.sv
// ----------------------------------------------------------------------------
// rsp_front - sprite stream parser
// Tracks header, offset table and skip/run/pixel structure of each sprite,
// holds the configuration registers and tags every request for the back end.
// ----------------------------------------------------------------------------
module rsp_front #(
  parameter int unsigned TABLE_ENTRIES = 256
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rsp_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [rsp_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             in_valid_i,
  input  logic                             kind_i,
  input  logic [7:0]                       data_byte_i,
  input  logic [7:0]                       table_index_i,
  input  logic                             full_i,
  output logic                             push_o,
  output rsp_pkg::rsp_item_t               item_o
);
  import rsp_pkg::*;

  rsp_phase_e  phase_q, phase_d;
  logic [16:0] byte_cnt_q, byte_cnt_d;
  logic [15:0] width_q, width_d;
  logic [15:0] rows_q, rows_d;
  logic [16:0] covered_q, covered_d;
  logic [7:0]  run_q, run_d;
  logic [8:0]  thr_q;
  logic        enable_q;

  logic        accept;
  logic        sprite_acc;
  logic [16:0] byte_cnt_inc;
  logic        offsets_done;
  logic [16:0] covered_run;
  logic [7:0]  run_dec;
  logic [16:0] covered_fin;
  logic        row_end;
  logic [15:0] rows_dec;
  logic        sprite_end;
  logic [15:0] hdr_rows;
  logic        is_pixel;
  logic        last;

  assign accept     = in_valid_i & ~full_i;
  assign sprite_acc = accept & (kind_i == KIND_SPRITE);
  assign push_o     = accept;

  assign byte_cnt_inc = byte_cnt_q + 17'd1;
  assign offsets_done = byte_cnt_inc >= {rows_q, 1'b0};
  assign covered_run  = covered_q + {9'd0, data_byte_i};
  assign run_dec      = run_q - 8'd1;
  assign covered_fin  = (phase_q == PH_RUN) ? covered_run : covered_q;
  assign row_end      = covered_fin >= {1'b0, width_q};
  assign rows_dec     = rows_q - 16'd1;
  assign sprite_end   = row_end && (rows_dec == 16'd0);
  assign hdr_rows     = (byte_cnt_q[1:0] == HDR_LAST) ? {data_byte_i, rows_q[7:0]} : rows_q;

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    if (sprite_acc) begin
      unique case (phase_q)
        PH_OFFSETS: begin
          if (offsets_done) begin
            phase_d = (width_q == 16'd0) ? PH_HEADER : PH_SKIP;
          end
        end
        PH_SKIP: phase_d = PH_RUN;
        PH_RUN: begin
          if (data_byte_i != 8'd0) begin
            phase_d = PH_PIXELS;
          end else begin
            phase_d = sprite_end ? PH_HEADER : PH_SKIP;
          end
        end
        PH_PIXELS: begin
          if (run_dec == 8'd0) begin
            phase_d = sprite_end ? PH_HEADER : PH_SKIP;
          end
        end
        default: begin
          if (byte_cnt_q[1:0] == HDR_LAST) begin
            phase_d = (hdr_rows == 16'd0) ? PH_HEADER : PH_OFFSETS;
          end else begin
            phase_d = PH_HEADER;
          end
        end
      endcase
    end
  end

  // Counters and per-request tags.
  always_comb begin
    byte_cnt_d = byte_cnt_q;
    width_d    = width_q;
    rows_d     = rows_q;
    covered_d  = covered_q;
    run_d      = run_q;
    is_pixel   = 1'b0;
    last       = 1'b0;
    if (sprite_acc) begin
      unique case (phase_q)
        PH_OFFSETS: begin
          byte_cnt_d = byte_cnt_inc;
          if (offsets_done) begin
            if (width_q == 16'd0) begin
              byte_cnt_d = '0;
              last       = 1'b1;
            end else begin
              covered_d = '0;
            end
          end
        end
        PH_SKIP: covered_d = covered_run;
        PH_RUN, PH_PIXELS: begin
          if (phase_q == PH_RUN) begin
            covered_d = covered_run;
            run_d     = data_byte_i;
          end else begin
            is_pixel = 1'b1;
            run_d    = run_dec;
          end
          // A pair is complete on a zero run byte or on its final pixel.
          if ((phase_q == PH_RUN && data_byte_i == 8'd0) ||
              (phase_q == PH_PIXELS && run_dec == 8'd0)) begin
            if (row_end) begin
              covered_d = '0;
              rows_d    = rows_dec;
              if (rows_dec == 16'd0) begin
                byte_cnt_d = '0;
                last       = 1'b1;
              end
            end
          end
        end
        default: begin
          case (byte_cnt_q[1:0])
            2'd0:    width_d = {8'd0, data_byte_i};
            2'd1:    width_d = {data_byte_i, width_q[7:0]};
            2'd2:    rows_d  = {8'd0, data_byte_i};
            default: rows_d  = hdr_rows;
          endcase
          if (byte_cnt_q[1:0] == HDR_LAST) begin
            byte_cnt_d = '0;
            covered_d  = '0;
            run_d      = '0;
            last       = (hdr_rows == 16'd0);
          end else begin
            byte_cnt_d = {15'd0, byte_cnt_q[1:0]} + 17'd1;
          end
        end
      endcase
    end
  end

  always_comb begin
    item_o.kind      = kind_i;
    item_o.data      = data_byte_i;
    item_o.index     = table_index_i;
    item_o.is_pixel  = is_pixel;
    item_o.last      = last;
    item_o.use_remap = is_pixel & enable_q & ({1'b0, data_byte_i} >= thr_q) &
                       ({1'b0, data_byte_i} < 9'(TABLE_ENTRIES));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HEADER;
      byte_cnt_q <= '0;
      width_q    <= '0;
      rows_q     <= '0;
      covered_q  <= '0;
      run_q      <= '0;
    end else begin
      phase_q    <= phase_d;
      byte_cnt_q <= byte_cnt_d;
      width_q    <= width_d;
      rows_q     <= rows_d;
      covered_q  <= covered_d;
      run_q      <= run_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= '0;
      enable_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_THRESHOLD: thr_q    <= cfg_data_i;
        CFG_ENABLE:    enable_q <= cfg_data_i[0];
        default:       ;
      endcase
    end
  end

endmodule

>>> hdl/rsp_queue.sv
// ----------------------------------------------------------------------------
// rsp_queue - short queue between parser and remap stage
// Holds classified requests so that either side may stall on its own.
// ----------------------------------------------------------------------------
module rsp_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  rsp_pkg::rsp_item_t item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output rsp_pkg::rsp_item_t item_o
);
  import rsp_pkg::*;

  rsp_item_t         slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QPTR_W:0]   cnt_q;

  assign full_o  = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (QPTR_W+1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (QPTR_W+1)'(1);
      end
    end
  end

endmodule

>>> hdl/rsp_back.sv
// ----------------------------------------------------------------------------
// rsp_back - remap table and output register
// Applies table writes in order and looks up tagged pixels, presenting each
// sprite byte in a registered output stage.
// ----------------------------------------------------------------------------
module rsp_back #(
  parameter int unsigned TABLE_ENTRIES = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  rsp_pkg::rsp_item_t item_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         out_byte_o,
  output logic               is_pixel_o,
  output logic               sprite_last_o
);
  import rsp_pkg::*;

  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  logic [7:0] table_q [TABLE_ENTRIES];
  logic [7:0] lookup_q;
  logic       out_valid_q, out_valid_d;
  logic [7:0] byte_q;
  logic       pixel_q, last_q, remap_q;
  logic       is_table;
  logic       take_sprite;

  assign is_table    = (item_i.kind == KIND_TABLE);
  assign pop_o       = valid_i & (is_table | ~out_valid_q | ~out_stall_i);
  assign take_sprite = pop_o & ~is_table;

  always_ff @(posedge clk_i) begin
    if (pop_o && is_table && ({1'b0, item_i.index} < 9'(TABLE_ENTRIES))) begin
      table_q[item_i.index[IdxW-1:0]] <= item_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_sprite) begin
      lookup_q <= table_q[item_i.data[IdxW-1:0]];
      byte_q   <= item_i.data;
      pixel_q  <= item_i.is_pixel;
      last_q   <= item_i.last;
      remap_q  <= item_i.use_remap;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q & out_stall_i;
    if (take_sprite) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = remap_q ? lookup_q : byte_q;
  assign is_pixel_o    = pixel_q;
  assign sprite_last_o = last_q;

endmodule

>>> hdl/rle_sprite_palette_remap_top.sv
// ----------------------------------------------------------------------------
// rle_sprite_palette_remap_top - streaming palette remap of run-length sprites
// Parses sprite bytes, remaps pixels inside runs through a loadable table.
// ----------------------------------------------------------------------------
// Usage. Requests arrive on the input channel (in_valid_i / in_stall_o). A
// request of kind sprite carries one byte of the sprite stream and yields
// exactly one result on the output channel (out_valid_o / out_stall_i); a
// request of kind table write loads one remap table entry and yields none.
// Table writes and sprite bytes take effect strictly in arrival order, so a
// table entry may be reloaded between two pixels.
// Throughput is one request per cycle while in_stall_o is low, set by the
// single parser step and the one-per-cycle table port. A result is registered
// twice: the accepting edge writes the classified request into the queue, and
// a later pop moves it through the table read into the output register. The
// configuration port (cfg_we_i, cfg_idx_i, cfg_data_i) sets the remap
// threshold and the enable bit; the user writes it only while the block is
// idle, which the block itself does not enforce. Reset clears the parser to
// expect a header and empties the queue and the output register; the remap
// table holds no defined values until loaded. When the receiver stalls, the
// output register holds its result, the queue fills, and in_stall_o rises
// once its four entries are taken.
// ----------------------------------------------------------------------------
module rle_sprite_palette_remap_top #(
  parameter int unsigned TABLE_ENTRIES = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rsp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rsp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           kind_i,
  input  logic [7:0]                     data_byte_i,
  input  logic [7:0]                     table_index_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [7:0]                     out_byte_o,
  output logic                           is_pixel_o,
  output logic                           sprite_last_o
);
  import rsp_pkg::*;

  // Front end to queue.
  logic      push;
  logic      full;
  rsp_item_t front_item;

  // Queue to back end.
  logic      head_valid;
  logic      pop;
  rsp_item_t head_item;

  // The parser accepts whenever the queue has room; it never looks at the
  // output side, which is what lets the two halves stall independently.
  assign in_stall_o = full;

  rsp_front #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .kind_i        (kind_i),
    .data_byte_i   (data_byte_i),
    .table_index_i (table_index_i),
    .full_i        (full),
    .push_o        (push),
    .item_o        (front_item)
  );

  rsp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .item_o  (head_item)
  );

  // The back end drains table writes even while the output is stalled, and
  // moves a sprite byte on only when the output register is free or emptying.
  rsp_back #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (head_valid),
    .item_i        (head_item),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .is_pixel_o    (is_pixel_o),
    .sprite_last_o (sprite_last_o)
  );

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - regression bench for the sprite palette remap block
// Streams run-length sprites and remap table loads into the block. Every
// accepted request is run through a local parser and palette model, and each
// result is checked against it in order. A short table of hand-picked
// requests comes first. Random sprites follow over several register settings
// and handshake idling patterns.
// ----------------------------------------------------------------------------
module tb_top;
  import rsp_pkg::*;

  // Generous bound on the whole run; the slowest legal run is far below it.
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  // Requests sent per random phase, counted from the start of that phase.
  localparam int unsigned PHASE_ITEMS   = 250;
  // Cycles allowed after the last result for a trailing table load to finish.
  localparam int unsigned SETTLE_CYCLES = 8;

  // One result as the block presents it.
  typedef struct packed {
    logic [7:0] value;
    logic       pixel;
    logic       last;
  } remap_out_t;

  // A row of the directed table. Where typed is set, result holds the answer
  // written out by hand; otherwise the local model supplies it.
  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic [7:0] index;
    logic       typed;
    remap_out_t result;
  } directed_row_t;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  typedef struct packed {
    logic [8:0] threshold;
    logic       enable;
    idle_mode_e idling;
  } phase_plan_t;

  // The directed part, in the order it is sent. Reset settings apply: the
  // threshold is zero and remapping is enabled, so every pixel is remapped.
  localparam directed_row_t DIRECTED_ROWS [26] = '{
    // Load the two extreme table entries so that the pixels below are defined.
    '{KIND_TABLE,  8'h00, 8'hFF, 1'b0, '{8'h00, 1'b0, 1'b0}},
    '{KIND_TABLE,  8'hFF, 8'h00, 1'b0, '{8'h00, 1'b0, 1'b0}},
    // Zero height: the sprite is over on the last header byte.
    '{KIND_SPRITE, 8'h05, 8'h00, 1'b1, '{8'h05, 1'b0, 1'b0}},
    '{KIND_SPRITE, 8'h01, 8'hFF, 1'b1, '{8'h01, 1'b0, 1'b0}},
    '{KIND_SPRITE, 8'h00, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b0}},
    '{KIND_SPRITE, 8'h00, 8'hFF, 1'b1, '{8'h00, 1'b0, 1'b1}},
    // Zero width, one row: the sprite is over on the last offset byte.
    '{KIND_SPRITE, 8'h00, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b0}},
    '{KIND_SPRITE, 8'h00, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b0}},
    '{KIND_SPRITE, 8'h01, 8'h00, 1'b1, '{8'h01, 1'b0, 1'b0}},
    '{KIND_SPRITE, 8'h00, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b0}},
    '{KIND_SPRITE, 8'hAA, 8'h00, 1'b1, '{8'hAA, 1'b0, 1'b0}},
    '{KIND_SPRITE, 8'h55, 8'h00, 1'b1, '{8'h55, 1'b0, 1'b1}},
    // Width three, one row, with offsets at both byte extremes.
    '{KIND_SPRITE, 8'h03, 8'h00, 1'b1, '{8'h03, 1'b0, 1'b0}},
    '{KIND_SPRITE, 8'h00, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b0}},
    '{KIND_SPRITE, 8'h01, 8'h00, 1'b1, '{8'h01, 1'b0, 1'b0}},
    '{KIND_SPRITE, 8'h00, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b0}},
    '{KIND_SPRITE, 8'hFF, 8'h00, 1'b1, '{8'hFF, 1'b0, 1'b0}},
    '{KIND_SPRITE, 8'h00, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b0}},
    // A pair with a zero run: no pixels, and the row is not yet covered.
    '{KIND_SPRITE, 8'h00, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b0}},
    '{KIND_SPRITE, 8'h00, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b0}},
    // A run of two pixels at the value extremes, remapped through the table.
    '{KIND_SPRITE, 8'h00, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b0}},
    '{KIND_SPRITE, 8'h02, 8'h00, 1'b1, '{8'h02, 1'b0, 1'b0}},
    '{KIND_SPRITE, 8'hFF, 8'hFF, 1'b0, '{8'h00, 1'b0, 1'b0}},
    '{KIND_SPRITE, 8'h00, 8'h00, 1'b0, '{8'h00, 1'b0, 1'b0}},
    // A skip far past the width: the row ends on the run byte of that pair.
    '{KIND_SPRITE, 8'hFF, 8'h00, 1'b1, '{8'hFF, 1'b0, 1'b0}},
    '{KIND_SPRITE, 8'h00, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b1}}
  };

  // Register settings and idling per random phase, the extremes among them.
  localparam phase_plan_t PHASE_PLANS [8] = '{
    '{9'd0,   1'b1, IDLE_NONE},
    '{9'd256, 1'b1, IDLE_SENDER},
    '{9'd255, 1'b1, IDLE_RECEIVER},
    '{9'd1,   1'b1, IDLE_BOTH},
    '{9'd77,  1'b0, IDLE_NONE},
    '{9'd128, 1'b1, IDLE_SENDER},
    '{9'd200, 1'b1, IDLE_RECEIVER},
    '{9'd0,   1'b0, IDLE_BOTH}
  };

  // --------------------------------------------------------------------------
  // Clock, reset and the signals around the block
  // --------------------------------------------------------------------------
  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic                  kind;
  logic [7:0]            data_byte;
  logic [7:0]            table_index;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [7:0]            out_byte;
  logic                  is_pixel;
  logic                  sprite_last;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  rle_sprite_palette_remap_top u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .kind_i        (kind),
    .data_byte_i   (data_byte),
    .table_index_i (table_index),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .out_byte_o    (out_byte),
    .is_pixel_o    (is_pixel),
    .sprite_last_o (sprite_last)
  );

  // --------------------------------------------------------------------------
  // Local model of the parser, the palette and the two registers
  // --------------------------------------------------------------------------
  rsp_phase_e  stream_phase;
  logic [16:0] byte_count;
  logic [15:0] spr_width;
  logic [15:0] rows_remaining;
  logic [16:0] covered;
  logic [7:0]  pixels_left;
  logic [8:0]  cfg_threshold;
  logic        cfg_enable;
  logic [7:0]  palette [256];
  bit          palette_loaded [256];

  // Results still owed by the block, oldest first.
  remap_out_t  expected_bytes [$];

  int unsigned mismatches;
  int unsigned requests_sent;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  function automatic bit chance(input int unsigned pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // True when a pixel of this value is taken from the palette.
  function automatic bit palette_applies(input logic [7:0] v);
    return cfg_enable && ({1'b0, v} >= cfg_threshold);
  endfunction

  // A pair is complete. The row closes once its covered count reaches the
  // width, and the sprite closes with its last row. Returns the last flag.
  function automatic logic close_pair();
    if (covered >= {1'b0, spr_width}) begin
      covered        = '0;
      rows_remaining = rows_remaining - 16'd1;
      if (rows_remaining == 16'd0) begin
        stream_phase = PH_HEADER;
        byte_count   = '0;
        return 1'b1;
      end
    end
    stream_phase = PH_SKIP;
    return 1'b0;
  endfunction

  // Moves the parser on by one sprite byte and returns the result it gives.
  function automatic remap_out_t advance_parser(input logic [7:0] b);
    remap_out_t r;
    r.value = b;
    r.pixel = 1'b0;
    r.last  = 1'b0;
    case (stream_phase)
      PH_OFFSETS: begin
        byte_count = byte_count + 17'd1;
        if (byte_count >= {rows_remaining, 1'b0}) begin
          if (spr_width == 16'd0) begin
            stream_phase = PH_HEADER;
            byte_count   = '0;
            r.last       = 1'b1;
          end else begin
            stream_phase = PH_SKIP;
            covered      = '0;
          end
        end
      end
      PH_SKIP: begin
        covered      = covered + {9'd0, b};
        stream_phase = PH_RUN;
      end
      PH_RUN: begin
        covered     = covered + {9'd0, b};
        pixels_left = b;
        if (b != 8'd0) begin
          stream_phase = PH_PIXELS;
        end else begin
          r.last = close_pair();
        end
      end
      PH_PIXELS: begin
        r.pixel = 1'b1;
        if (palette_applies(b)) begin
          r.value = palette[b];
        end
        pixels_left = pixels_left - 8'd1;
        if (pixels_left == 8'd0) begin
          r.last = close_pair();
        end
      end
      default: begin
        // Header bytes: width then height, both little endian.
        case (byte_count[1:0])
          2'd0:    spr_width = {8'd0, b};
          2'd1:    spr_width[15:8] = spr_width[15:8] | b;
          2'd2:    rows_remaining = {8'd0, b};
          default: rows_remaining[15:8] = rows_remaining[15:8] | b;
        endcase
        if (byte_count[1:0] == HDR_LAST) begin
          byte_count  = '0;
          covered     = '0;
          pixels_left = '0;
          if (rows_remaining == 16'd0) begin
            stream_phase = PH_HEADER;
            r.last       = 1'b1;
          end else begin
            stream_phase = PH_OFFSETS;
          end
        end else begin
          byte_count   = {15'd0, byte_count[1:0]} + 17'd1;
          stream_phase = PH_HEADER;
        end
      end
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  // Presents one request, holding it through any stall, and folds it into the
  // model at the edge where it is taken. A typed result, where given, stands
  // in for the model's answer but the model still moves on.
  task automatic send_request(input logic k, input logic [7:0] d, input logic [7:0] ix,
                              input logic typed, input remap_out_t typed_result);
    remap_out_t r;
    while (chance(send_idle_pct)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    kind        <= k;
    data_byte   <= d;
    table_index <= ix;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    if (k == KIND_TABLE) begin
      palette[ix]        = d;
      palette_loaded[ix] = 1'b1;
    end else begin
      r = advance_parser(d);
      expected_bytes.push_back(typed ? typed_result : r);
    end
    requests_sent++;
  endtask

  // Sends one sprite byte. A pixel that would read a palette entry never
  // loaded gets that entry loaded first; other table loads are sprinkled in
  // at random so that entries change between pixels.
  task automatic send_sprite_byte(input logic [7:0] b);
    if (stream_phase == PH_PIXELS && palette_applies(b) && !palette_loaded[b]) begin
      send_request(KIND_TABLE, 8'($urandom_range(0, 255)), b, 1'b0, '0);
    end
    if (chance(8)) begin
      send_request(KIND_TABLE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   1'b0, '0);
    end
    send_request(KIND_SPRITE, b, 8'($urandom_range(0, 255)), 1'b0, '0);
  endtask

  // Picks the next byte of the stream from where the parser stands. Noise
  // drops the shaping of skips and runs. Header bytes are always kept small,
  // so that a sprite begun by accident stays short.
  function automatic logic [7:0] choose_stream_byte(input bit noise);
    logic [7:0] b;
    logic [8:0] t;
    b = 8'($urandom_range(0, 255));
    t = cfg_threshold;
    case (stream_phase)
      PH_OFFSETS: ;
      PH_SKIP: begin
        if (!noise && spr_width <= 16'd64 && $urandom_range(0, 9) != 0) begin
          b = 8'($urandom_range(0, 3));
        end
      end
      PH_RUN: begin
        if (!noise && $urandom_range(0, 15) != 0) begin
          b = 8'($urandom_range(0, (spr_width > 16'd64) ? 40 : 6));
        end
      end
      PH_PIXELS: begin
        // Lean on the value extremes and both sides of the threshold.
        case ($urandom_range(0, 5))
          0:       b = 8'h00;
          1:       b = 8'hFF;
          2:       b = t[7:0] - 8'd1;
          3:       b = t[7:0];
          default: ;
        endcase
      end
      default: b = byte_count[0] ? 8'd0 : 8'($urandom_range(0, 3));
    endcase
    return b;
  endfunction

  // One sprite from a clean header onwards. Now and then a burst of noise is
  // thrown in partway; the sprite is then walked on from wherever the parser
  // lands until it waits for a fresh header again.
  task automatic run_sprite();
    logic [15:0] w;
    logic [15:0] h;
    bit          broken;
    int          noise_at;
    int          n;
    case ($urandom_range(0, 19))
      0:       w = 16'd0;
      1:       w = 16'($urandom_range(65, 400));
      default: w = 16'($urandom_range(1, 24));
    endcase
    h        = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 3));
    broken   = ($urandom_range(0, 7) == 0);
    noise_at = $urandom_range(0, 20);
    n        = 0;
    send_sprite_byte(w[7:0]);
    send_sprite_byte(w[15:8]);
    send_sprite_byte(h[7:0]);
    send_sprite_byte(h[15:8]);
    while (stream_phase != PH_HEADER || byte_count != '0) begin
      if (broken && n == noise_at) begin
        repeat ($urandom_range(1, 4)) send_sprite_byte(choose_stream_byte(1'b1));
      end else begin
        send_sprite_byte(choose_stream_byte(1'b0));
      end
      n++;
    end
  endtask

  // Stops offering requests and waits until every owed result has come,
  // then gives a table load still on its way time to finish.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Called only with the block idle. Both registers are written back to
  // back, one per edge, and the model follows.
  task automatic apply_plan(input phase_plan_t plan);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_THRESHOLD;
    cfg_data <= plan.threshold;
    @(posedge clk);
    cfg_idx  <= CFG_ENABLE;
    cfg_data <= {{(CFG_DATA_W - 1){1'b0}}, plan.enable};
    @(posedge clk);
    cfg_we        <= 1'b0;
    cfg_threshold  = plan.threshold;
    cfg_enable     = plan.enable;
    case (plan.idling)
      IDLE_SENDER: begin
        send_idle_pct  = 78;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct  = 0;
        recv_stall_pct = 78;
      end
      IDLE_BOTH: begin
        send_idle_pct  = 9;
        recv_stall_pct = 9;
      end
      default: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------
  // The stall is redrawn every cycle, independent of what the block shows.
  always @(posedge clk) begin
    out_stall <= chance(recv_stall_pct);
  end

  task automatic flag_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatches++;
  endtask

  // A result is taken at an edge where it is valid and not stalled; it must
  // match the oldest owed result in every field.
  always @(posedge clk) begin
    remap_out_t owed;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_bytes.size() == 0) begin
        flag_mismatch($sformatf("result %02h with none owed", out_byte));
      end else begin
        owed = expected_bytes.pop_front();
        if (out_byte !== owed.value) begin
          flag_mismatch($sformatf("out_byte %02h, expected %02h", out_byte, owed.value));
        end
        if (is_pixel !== owed.pixel) begin
          flag_mismatch($sformatf("is_pixel %b, expected %b", is_pixel, owed.pixel));
        end
        if (sprite_last !== owed.last) begin
          flag_mismatch($sformatf("sprite_last %b, expected %b", sprite_last, owed.last));
        end
      end
    end
  end

  // Hard stop should the block hang.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("rle_sprite_palette_remap_top regression: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_idx        <= '0;
    cfg_data       <= '0;
    in_valid       <= 1'b0;
    kind           <= KIND_SPRITE;
    data_byte      <= '0;
    table_index    <= '0;
    mismatches     = 0;
    requests_sent  = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // Model state after reset. The palette stays unloaded; the senders make
    // sure no pixel ever reads an entry before it has been loaded.
    stream_phase   = PH_HEADER;
    byte_count     = '0;
    spr_width      = '0;
    rows_remaining = '0;
    covered        = '0;
    pixels_left    = '0;
    cfg_threshold  = '0;
    cfg_enable     = 1'b1;
    foreach (palette_loaded[i]) palette_loaded[i] = 1'b0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, run with the reset register values and no idling.
    foreach (DIRECTED_ROWS[i]) begin
      send_request(DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].index,
                   DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].result);
    end

    // Random part: each phase starts from an idle block with new settings.
    // A sprite left unfinished at the end of a phase simply carries on into
    // the next one, since the parser keeps its place across register writes.
    foreach (PHASE_PLANS[p]) begin
      int unsigned phase_start;
      drain();
      apply_plan(PHASE_PLANS[p]);
      phase_start = requests_sent;
      while (requests_sent - phase_start < PHASE_ITEMS) begin
        run_sprite();
      end
    end
    drain();

    if (mismatches == 0) begin
      $display("rle_sprite_palette_remap_top regression: pass");
    end else begin
      $display("rle_sprite_palette_remap_top regression: fail");
    end
    $finish;
  end

endmodule
